// ----- hdl/c2sa_pkg.sv -----
// Shared types, constants and the arctangent table for the cartesian to
// spherical angle unit. No dependencies.
package c2sa_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 18;

    // Guarded differences are 59 bits; two more bits cover CORDIC growth.
    localparam int SCALED_W = 59;
    localparam int DW       = SCALED_W + 2;
    // Q30 angle accumulator
    localparam int ZW       = 34;
    localparam int Q30_SHIFT = 30;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam longint               PI_Q30      = 64'sd3373259426;
    localparam logic [29:0]          INV_GAIN_Q30 = 30'd652032874;

    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_ORIGIN_Z = 2'd2
    } cfg_index_t;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 34'sh3243F6A8;
            5'd1:    v = 34'sh1DAC6705;
            5'd2:    v = 34'sh0FADBAFC;
            5'd3:    v = 34'sh07F56EA6;
            5'd4:    v = 34'sh03FEAB76;
            5'd5:    v = 34'sh01FFD55B;
            5'd6:    v = 34'sh00FFFAAA;
            5'd7:    v = 34'sh007FFF55;
            5'd8:    v = 34'sh003FFFEA;
            5'd9:    v = 34'sh001FFFFD;
            5'd10:   v = 34'sh000FFFFF;
            5'd11:   v = 34'sh0007FFFF;
            5'd12:   v = 34'sh0003FFFF;
            5'd13:   v = 34'sh0001FFFF;
            5'd14:   v = 34'sh0000FFFF;
            5'd15:   v = 34'sh00007FFF;
            5'd16:   v = 34'sh00003FFF;
            5'd17:   v = 34'sh00001FFF;
            5'd18:   v = 34'sh00000FFF;
            5'd19:   v = 34'sh000007FF;
            5'd20:   v = 34'sh000003FF;
            5'd21:   v = 34'sh000001FF;
            5'd22:   v = 34'sh000000FF;
            5'd23:   v = 34'sh0000007F;
            5'd24:   v = 34'sh0000003F;
            5'd25:   v = 34'sh0000001F;
            5'd26:   v = 34'sh0000000F;
            5'd27:   v = 34'sh00000008;
            5'd28:   v = 34'sh00000004;
            5'd29:   v = 34'sh00000002;
            5'd30:   v = 34'sh00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/cartesian_to_spherical_angles_core.sv -----
// Top level of the cartesian to spherical angle unit: origin registers,
// difference stage and the CORDIC pipeline. Depends on c2sa_pkg, c2sa_cordic,
// c2sa_gain and c2sa_out.
//
// Usage:
//   Pulse start with pos_x/pos_y/pos_z to transfer one point. busy stays low,
//   so a point can be transferred on every clock cycle.
//   The origin is written over the cfg channel (cfg_valid, cfg_ready,
//   cfg_index, cfg_data); cfg_ready is always high. Index 0, 1, 2 select
//   origin x, y, z; other indices are dropped. Write only while no point is
//   in flight.
//   Each point yields one result: polar_angle and azimuth_angle, valid for
//   one cycle while done is high. The path from the transfer edge is one
//   difference stage, two CORDIC chains of CORDIC_STAGES+1 stages each, two
//   gain-product stages and an output stage. Throughput is one point per cycle.
//   The receiver cannot stall; results are not held.
//   Reset clears the origin to zero and drops every point in flight.
module cartesian_to_spherical_angles_core
    import c2sa_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [COORD_WIDTH-1:0]      pos_x,
    input  logic [COORD_WIDTH-1:0]      pos_y,
    input  logic [COORD_WIDTH-1:0]      pos_z,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [COORD_WIDTH-1:0]      cfg_data,
    output logic                        done,
    output logic [FRAC_BITS+1:0]        polar_angle,
    output logic signed [FRAC_BITS+2:0] azimuth_angle
);

    localparam int GUARD  = 58 - COORD_WIDTH;
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PAD_W  = DW - DIFF_W - GUARD;

    logic [COORD_WIDTH-1:0] origin_x_reg;
    logic [COORD_WIDTH-1:0] origin_y_reg;
    logic [COORD_WIDTH-1:0] origin_z_reg;

    logic                 in_valid_reg;
    logic signed [DW-1:0] dx_reg;
    logic signed [DW-1:0] dy_reg;
    logic signed [DW-1:0] dz_reg;
    logic [DIFF_W-1:0]    ddx;
    logic [DIFF_W-1:0]    ddy;
    logic [DIFF_W-1:0]    ddz;
    logic signed [DW-1:0] dx_next;
    logic signed [DW-1:0] dy_next;
    logic signed [DW-1:0] dz_next;

    logic                 c1_valid;
    logic signed [DW-1:0] c1_mag;
    logic signed [ZW-1:0] c1_angle;
    logic [DW-1:0]        c1_dz;

    logic                 g_valid;
    logic signed [DW-1:0] g_r;
    logic [DW+ZW-1:0]     g_side;

    logic                 c2_valid;
    logic signed [DW-1:0] c2_mag;
    logic signed [ZW-1:0] c2_angle;
    logic [ZW-1:0]        c2_azimuth;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                CFG_ORIGIN_Z: origin_z_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        ddx = {pos_x[COORD_WIDTH-1], pos_x} - {origin_x_reg[COORD_WIDTH-1], origin_x_reg};
        ddy = {pos_y[COORD_WIDTH-1], pos_y} - {origin_y_reg[COORD_WIDTH-1], origin_y_reg};
        ddz = {pos_z[COORD_WIDTH-1], pos_z} - {origin_z_reg[COORD_WIDTH-1], origin_z_reg};
        dx_next = {{PAD_W{ddx[DIFF_W-1]}}, ddx, {GUARD{1'b0}}};
        dy_next = {{PAD_W{ddy[DIFF_W-1]}}, ddy, {GUARD{1'b0}}};
        dz_next = {{PAD_W{ddz[DIFF_W-1]}}, ddz, {GUARD{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        dz_reg <= dz_next;
    end

    c2sa_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (DW)
    ) u_cordic_xy (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_x      (dx_reg),
        .in_y      (dy_reg),
        .in_side   (dz_reg),
        .out_valid (c1_valid),
        .out_mag   (c1_mag),
        .out_angle (c1_angle),
        .out_side  (c1_dz)
    );

    c2sa_gain #(
        .SIDE_W (DW + ZW)
    ) u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c1_valid),
        .in_mag    (c1_mag),
        .in_side   ({c1_dz, c1_angle}),
        .out_valid (g_valid),
        .out_r     (g_r),
        .out_side  (g_side)
    );

    c2sa_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (ZW)
    ) u_cordic_zr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_valid),
        .in_x      (g_side[DW+ZW-1:ZW]),
        .in_y      (g_r),
        .in_side   (g_side[ZW-1:0]),
        .out_valid (c2_valid),
        .out_mag   (c2_mag),
        .out_angle (c2_angle),
        .out_side  (c2_azimuth)
    );

    c2sa_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (c2_valid && (c2_mag[0] || !c2_mag[0])),
        .in_polar      (c2_angle),
        .in_azimuth    (c2_azimuth),
        .done          (done),
        .polar_angle   (polar_angle),
        .azimuth_angle (azimuth_angle)
    );

endmodule

// ----- hdl/c2sa_cordic.sv -----
// Pipelined CORDIC vectoring unit: quadrant pre-rotation stage then one
// register stage per iteration. Depends on c2sa_pkg.
module c2sa_cordic
    import c2sa_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter int SIDE_W = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [DW-1:0] in_x,
    input  logic signed [DW-1:0] in_y,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic signed [DW-1:0] out_mag,
    output logic signed [ZW-1:0] out_angle,
    output logic [SIDE_W-1:0]    out_side
);

    logic                 valid_reg [0:STAGES];
    logic                 zero_reg  [0:STAGES];
    logic signed [DW-1:0] x_reg     [0:STAGES];
    logic signed [DW-1:0] y_reg     [0:STAGES];
    logic signed [ZW-1:0] z_reg     [0:STAGES];
    logic [SIDE_W-1:0]    side_reg  [0:STAGES];

    logic signed [DW-1:0] x0_next;
    logic signed [DW-1:0] y0_next;
    logic signed [ZW-1:0] z0_next;
    logic                 zero0_next;

    always_comb
    begin
        zero0_next = (in_x == '0) && (in_y == '0);
        x0_next    = in_x;
        y0_next    = in_y;
        z0_next    = '0;
        if (in_x[DW-1])
        begin
            if (!in_y[DW-1])
            begin
                x0_next = in_y;
                y0_next = -in_x;
                z0_next = HALF_PI_Q30;
            end
            else
            begin
                x0_next = -in_y;
                y0_next = in_x;
                z0_next = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= zero0_next;
        x_reg[0]    <= x0_next;
        y_reg[0]    <= y0_next;
        z_reg[0]    <= z0_next;
        side_reg[0] <= in_side;
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        logic signed [DW-1:0] x_next;
        logic signed [DW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        always_comb
        begin
            if (!y_reg[i][DW-1])
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + atan_q30(5'(i));
            end
            else
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - atan_q30(5'(i));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            x_reg[i+1]    <= x_next;
            y_reg[i+1]    <= y_next;
            z_reg[i+1]    <= z_next;
            side_reg[i+1] <= side_reg[i];
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign out_mag   = x_reg[STAGES];
    assign out_angle = zero_reg[STAGES] ? '0 : z_reg[STAGES];
    assign out_side  = side_reg[STAGES];

endmodule

// ----- hdl/c2sa_gain.sv -----
// Two-stage removal of the CORDIC gain from the planar magnitude, split into
// high and low 30-bit partial products. Depends on c2sa_pkg.
module c2sa_gain
    import c2sa_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [DW-1:0] in_mag,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic signed [DW-1:0] out_r,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int PART_W = DW - 1 - Q30_SHIFT;
    localparam int PROD_W = PART_W + 30;

    logic              valid_a_reg;
    logic              valid_b_reg;
    logic [PROD_W-1:0] p_hi_reg;
    logic [59:0]       p_lo_reg;
    logic [SIDE_W-1:0] side_a_reg;
    logic [SIDE_W-1:0] side_b_reg;
    logic signed [DW-1:0] r_reg;
    logic [PROD_W-1:0] p_hi_next;
    logic [59:0]       p_lo_next;
    logic signed [DW-1:0] r_next;

    always_comb
    begin
        p_hi_next = in_mag[DW-2:Q30_SHIFT] * INV_GAIN_Q30;
        p_lo_next = in_mag[Q30_SHIFT-1:0] * INV_GAIN_Q30;
        r_next    = DW'(p_hi_reg) + DW'(p_lo_reg[59:Q30_SHIFT]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_hi_reg   <= p_hi_next;
        p_lo_reg   <= p_lo_next;
        side_a_reg <= in_side;
        r_reg      <= r_next;
        side_b_reg <= side_a_reg;
    end

    assign out_valid = valid_b_reg;
    assign out_r     = r_reg;
    assign out_side  = side_b_reg;

endmodule

// ----- hdl/c2sa_out.sv -----
// Output stage: round Q30 angles to the output format, saturate and register
// them with the done strobe. Depends on c2sa_pkg.
module c2sa_out
    import c2sa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic signed [ZW-1:0]   in_polar,
    input  logic signed [ZW-1:0]   in_azimuth,
    output logic                   done,
    output logic [FRAC_BITS+1:0]   polar_angle,
    output logic signed [FRAC_BITS+2:0] azimuth_angle
);

    localparam int     SHIFT   = Q30_SHIFT - FRAC_BITS;
    localparam longint HALF_L  = longint'(1) << (SHIFT - 1);
    localparam longint PI_L    = (PI_Q30 + HALF_L) >>> SHIFT;
    localparam logic signed [ZW-1:0] HALF    = ZW'(HALF_L);
    localparam logic signed [ZW-1:0] PI_OUT  = ZW'(PI_L);
    localparam logic signed [ZW-1:0] NEG_PI  = ZW'(-PI_L);

    logic                        done_reg;
    logic [FRAC_BITS+1:0]        polar_reg;
    logic signed [FRAC_BITS+2:0] azimuth_reg;
    logic signed [ZW-1:0]        polar_rnd;
    logic signed [ZW-1:0]        azimuth_rnd;
    logic signed [ZW-1:0]        polar_sat;
    logic signed [ZW-1:0]        azimuth_sat;

    always_comb
    begin
        polar_rnd   = (in_polar + HALF) >>> SHIFT;
        azimuth_rnd = (in_azimuth + HALF) >>> SHIFT;
        polar_sat   = polar_rnd;
        if (polar_rnd > PI_OUT)
        begin
            polar_sat = PI_OUT;
        end
        else if (polar_rnd < 0)
        begin
            polar_sat = '0;
        end
        azimuth_sat = azimuth_rnd;
        if (azimuth_rnd > PI_OUT)
        begin
            azimuth_sat = PI_OUT;
        end
        else if (azimuth_rnd < NEG_PI)
        begin
            azimuth_sat = NEG_PI;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        polar_reg   <= polar_sat[FRAC_BITS+1:0];
        azimuth_reg <= azimuth_sat[FRAC_BITS+2:0];
    end

    assign done          = done_reg;
    assign polar_angle   = polar_reg;
    assign azimuth_angle = azimuth_reg;

endmodule

// ----- sim/tb_cartesian_to_spherical_angles_core.sv -----
// Self-checking testbench for cartesian_to_spherical_angles_core: random and
// directed points against a bit-exact CORDIC angle predictor.
// Depends on c2sa_pkg and the core RTL.
module tb_cartesian_to_spherical_angles_core
    import c2sa_pkg::*;
();

    localparam int CW             = COORD_WIDTH_DEF;
    localparam int STAGES         = CORDIC_STAGES_DEF;
    localparam int GUARD_BITS     = 58 - CW;
    localparam int ANGLE_SHIFT    = Q30_SHIFT - FRAC_BITS_DEF;
    localparam int LATENCY        = 2 * STAGES + 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_POINTS   = 150;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [CW-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] COORD_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
    } point_t;

    typedef struct packed {
        logic [FRAC_BITS_DEF+1:0]        polar;
        logic signed [FRAC_BITS_DEF+2:0] azimuth;
    } angle_pair_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [CW-1:0]                   pos_x = '0;
    logic [CW-1:0]                   pos_y = '0;
    logic [CW-1:0]                   pos_z = '0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [CFG_IDX_W-1:0]            cfg_index = '0;
    logic [CW-1:0]                   cfg_data = '0;
    logic                            done;
    logic [FRAC_BITS_DEF+1:0]        polar_angle;
    logic signed [FRAC_BITS_DEF+2:0] azimuth_angle;

    point_t      pending_points[$];
    angle_pair_t angles_due[$];
    angle_pair_t head;
    logic [CW-1:0] org_x = '0;
    logic [CW-1:0] org_y = '0;
    logic [CW-1:0] org_z = '0;
    logic        point_taken = 1'b0;
    logic        gaps_on = 1'b0;
    int          gap_left = 0;
    int          stall_cycles = 0;
    int          mismatches = 0;

    cartesian_to_spherical_angles_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .polar_angle   (polar_angle),
        .azimuth_angle (azimuth_angle)
    );

    always #2 clk = ~clk;

    function automatic longint arctan_step(input int i);
        longint v;
        case (i)
            0:       v = 64'h3243F6A8;
            1:       v = 64'h1DAC6705;
            2:       v = 64'h0FADBAFC;
            3:       v = 64'h07F56EA6;
            4:       v = 64'h03FEAB76;
            5:       v = 64'h01FFD55B;
            6:       v = 64'h00FFFAAA;
            7:       v = 64'h007FFF55;
            8:       v = 64'h003FFFEA;
            9:       v = 64'h001FFFFD;
            10:      v = 64'h000FFFFF;
            11:      v = 64'h0007FFFF;
            12:      v = 64'h0003FFFF;
            13:      v = 64'h0001FFFF;
            14:      v = 64'h0000FFFF;
            15:      v = 64'h00007FFF;
            16:      v = 64'h00003FFF;
            17:      v = 64'h00001FFF;
            default: v = 0;
        endcase
        return v;
    endfunction

    // Q30 angle of (xi, yi); mag receives the gained magnitude.
    function automatic longint vector_angle(input longint xi, input longint yi,
                                            output longint mag);
        longint x, y, z, t, xs, ys;
        x = xi;
        y = yi;
        z = 0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            return 0;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = longint'(HALF_PI_Q30);
            end
            else
            begin
                x = -y;
                y = t;
                z = -longint'(HALF_PI_Q30);
            end
        end
        for (int i = 0; i < STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_step(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_step(i);
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic longint q30_to_angle(input longint z, input bit floor_zero);
        longint half, pi_out, a;
        half   = longint'(1) <<< (ANGLE_SHIFT - 1);
        pi_out = (PI_Q30 + half) >>> ANGLE_SHIFT;
        a      = (z + half) >>> ANGLE_SHIFT;
        if (a > pi_out)
            a = pi_out;
        if (floor_zero && a < 0)
            a = 0;
        if (!floor_zero && a < -pi_out)
            a = -pi_out;
        return a;
    endfunction

    function automatic angle_pair_t predict_angles(input point_t p, input logic [CW-1:0] ox,
                                                   input logic [CW-1:0] oy,
                                                   input logic [CW-1:0] oz);
        longint      dx, dy, dz, mag, mag2, zphi, zth, r;
        longint      polar_l, azimuth_l;
        logic [63:0] m;
        angle_pair_t res;
        dx = (longint'($signed(p.x)) - longint'($signed(ox))) <<< GUARD_BITS;
        dy = (longint'($signed(p.y)) - longint'($signed(oy))) <<< GUARD_BITS;
        dz = (longint'($signed(p.z)) - longint'($signed(oz))) <<< GUARD_BITS;
        zphi = vector_angle(dx, dy, mag);
        m = mag;
        r = longint'((m >> 30) * 64'(INV_GAIN_Q30)
                     + (((m & 64'h3FFF_FFFF) * 64'(INV_GAIN_Q30)) >> 30));
        zth = vector_angle(dz, r, mag2);
        polar_l     = q30_to_angle(zth, 1'b1);
        azimuth_l   = q30_to_angle(zphi, 1'b0);
        res.polar   = polar_l[FRAC_BITS_DEF+1:0];
        res.azimuth = azimuth_l[FRAC_BITS_DEF+2:0];
        return res;
    endfunction

    function automatic logic [CW-1:0] near_extreme(input logic [CW-1:0] o);
        logic [CW-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = COORD_MIN;
            1:       v = COORD_MAX;
            2:       v = '0;
            3:       v = o;
            4:       v = o + 1;
            default: v = o - 1;
        endcase
        return v;
    endfunction

    function automatic point_t random_point(input logic [CW-1:0] ox, input logic [CW-1:0] oy,
                                            input logic [CW-1:0] oz);
        point_t p;
        int     kind;
        kind = $urandom_range(0, 9);
        p.x = $urandom;
        p.y = $urandom;
        p.z = $urandom;
        case (kind)
            4, 5:
            begin
                p.x = ox + $urandom_range(0, 64) - 32;
                p.y = oy + $urandom_range(0, 64) - 32;
                p.z = oz + $urandom_range(0, 64) - 32;
            end
            6:
            begin
                if ($urandom_range(0, 1))
                    p.x = ox;
                if ($urandom_range(0, 1))
                    p.y = oy;
                if ($urandom_range(0, 2) == 0)
                    p.z = oz;
            end
            7:
            begin
                p.x = near_extreme(ox);
                p.y = near_extreme(oy);
                p.z = near_extreme(oz);
            end
            8, 9:
            begin
                p.x = ox + (($urandom >> $urandom_range(4, 28))
                            ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0));
                p.y = oy + (($urandom >> $urandom_range(4, 28))
                            ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0));
                p.z = oz + (($urandom >> $urandom_range(4, 28))
                            ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0));
            end
            default: ;
        endcase
        return p;
    endfunction

    // Point driver: changes inputs on the falling edge.
    always @(negedge clk)
    begin
        int r;
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left <= 0;
        end
        else if (start && !point_taken)
        begin
            // hold until the transfer completes
        end
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_points.size() > 0)
        begin
            {pos_x, pos_y, pos_z} <= pending_points.pop_front();
            start <= 1'b1;
            r = $urandom_range(0, 99);
            if (!gaps_on || r < 70)
                gap_left <= 0;
            else if (r < 96)
                gap_left <= $urandom_range(1, 3);
            else
                gap_left <= $urandom_range(10, 60);
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // Monitor: records transfers, tracks the origin and checks results.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            point_taken <= 1'b0;
            org_x <= '0;
            org_y <= '0;
            org_z <= '0;
        end
        else
        begin
            point_taken <= start && !busy;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ORIGIN_X: org_x <= cfg_data;
                    CFG_ORIGIN_Y: org_y <= cfg_data;
                    CFG_ORIGIN_Z: org_z <= cfg_data;
                    default: ;
                endcase
            end
            if (done)
            begin
                if (angles_due.size() == 0)
                begin
                    $error("result with no point outstanding: %s %0d %s %0d",
                           "polar_angle", polar_angle, "azimuth_angle", azimuth_angle);
                    mismatches++;
                end
                else
                begin
                    head = angles_due.pop_front();
                    if (polar_angle !== head.polar)
                    begin
                        $error("polar_angle: expected %0d, got %0d", head.polar, polar_angle);
                        mismatches++;
                    end
                    if (azimuth_angle !== head.azimuth)
                    begin
                        $error("azimuth_angle: expected %0d, got %0d",
                               head.azimuth, azimuth_angle);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                angles_due.push_back(predict_angles({pos_x, pos_y, pos_z}, org_x, org_y, org_z));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_cartesian_to_spherical_angles_core: done, errors");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_origin(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                input logic [CW-1:0] z);
        write_reg(CFG_ORIGIN_X, x);
        write_reg(CFG_SPARE, $urandom);
        write_reg(CFG_ORIGIN_Y, y);
        write_reg(CFG_ORIGIN_Z, z);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                              input logic [CW-1:0] z);
        pending_points.push_back({x, y, z});
    endtask

    task automatic await_drain();
        @(posedge clk);
        while (pending_points.size() != 0 || start || angles_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [CW-1:0] ox, oy, oz;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // origin at reset value
        push_point(0, 0, 0);
        push_point(1, 0, 0);
        push_point(-1, 0, 0);
        push_point(0, 1, 0);
        push_point(0, -1, 0);
        push_point(0, 0, 1);
        push_point(0, 0, -1);
        push_point(-1, -1, 5);
        push_point(-1, 1, -5);
        push_point(COORD_MAX, COORD_MAX, COORD_MAX);
        push_point(COORD_MIN, COORD_MIN, COORD_MIN);
        push_point(COORD_MIN, 0, COORD_MAX);
        push_point(0, COORD_MIN, 0);
        push_point(1, -1, 0);
        await_drain();

        write_origin(COORD_MAX, COORD_MIN, COORD_MAX);
        push_point(COORD_MIN, COORD_MAX, COORD_MIN);
        push_point(COORD_MAX, COORD_MIN, COORD_MAX);
        push_point(COORD_MIN, COORD_MIN, COORD_MAX);
        push_point(COORD_MAX, COORD_MAX, COORD_MIN);
        await_drain();

        write_origin(COORD_MIN, COORD_MAX, COORD_MIN);
        push_point(COORD_MAX, COORD_MIN, COORD_MAX);
        push_point(COORD_MIN, COORD_MAX, COORD_MAX);
        push_point(COORD_MIN, COORD_MAX, 0);
        push_point(COORD_MIN, COORD_MAX, COORD_MIN);
        await_drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
            begin
                ox = '0;
                oy = '0;
                oz = '0;
            end
            else if (p == 1)
            begin
                ox = COORD_MIN;
                oy = COORD_MAX;
                oz = COORD_MAX;
            end
            else
            begin
                ox = $urandom;
                oy = $urandom >> $urandom_range(0, 16);
                oz = $urandom;
            end
            write_origin(ox, oy, oz);
            gaps_on = (p % 2) == 1;
            for (int n = 0; n < PHASE_POINTS; n++)
                pending_points.push_back(random_point(ox, oy, oz));
            await_drain();
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0)
            $display("tb_cartesian_to_spherical_angles_core: done, clean");
        else
            $display("tb_cartesian_to_spherical_angles_core: done, errors");
        $finish;
    end

endmodule
